/* design/swdc_pkg.sv */
package swdc_pkg;

    // Field widths
    localparam int COORD_BITS = 16;
    localparam int TIME_BITS  = 32;
    localparam int MODE_W     = 2;
    localparam int DIR_W      = 3;

    // Event kinds
    localparam logic [MODE_W-1:0] MODE_DOWN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UP   = 2'd2;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd4;

    // Configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int MAXD_W     = 16;
    localparam int MIND_W     = 16;
    localparam int MINV_W     = 24;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DURATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VELOCITY = 2'd2;
    localparam logic [MAXD_W-1:0] MAXD_RESET = 16'd500;
    localparam logic [MIND_W-1:0] MIND_RESET = 16'd6554;
    localparam logic [MINV_W-1:0] MINV_RESET = 24'd8389;

    // Velocity test: products at or above 2^VEL_BITS always fail
    localparam int VEL_BITS   = 25;
    localparam int MUL_W      = (COORD_BITS > VEL_BITS) ? COORD_BITS : VEL_BITS;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int MUL_CNT_W  = $clog2(MUL_W + 1);
    localparam int DIST_W     = PROD_W + 1;
    localparam int DIST_SHIFT = 48 - 2 * COORD_BITS;
    localparam int LHS_W      = DIST_W + DIST_SHIFT;

    // Stream words
    localparam int IN_BITS    = MODE_W + 2 * COORD_BITS + TIME_BITS;
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DIR_W + 7) / 8) * 8;

endpackage

/* design/swipe_direction_classifier.sv */
// Touch down, spare and unarmed events pass from accept through ST_DONE to the output
// register; classified move/up events first wait in ST_MUL1 for the multipliers, and in
// ST_MUL2 too when the velocity test needs the squared-speed product. The waits are set
// by the bit-serial multipliers. One word in flight: the next input is taken the cycle
// after the result enters the output register (ST_DONE holds while the output stalls).
// Reset (aresetn low, synchronous) disarms, clears start point and output, and loads
// the default thresholds.
module swipe_direction_classifier (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input words
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [swdc_pkg::S_TDATA_W-1:0] s_tdata,   // mode, pos_x, pos_y, time_ms
    // result words
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [swdc_pkg::M_TDATA_W-1:0] m_tdata,   // direction
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [swdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swdc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL1 = 2'd1;
    localparam logic [1:0] ST_MUL2 = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam int CB = swdc_pkg::COORD_BITS;
    localparam int TB = swdc_pkg::TIME_BITS;
    localparam int MW = swdc_pkg::MUL_W;

    logic [1:0] state_reg;

    // thresholds
    logic [swdc_pkg::MAXD_W-1:0] max_dur_reg;
    logic [swdc_pkg::MIND_W-1:0] min_dist_reg;
    logic [swdc_pkg::MINV_W-1:0] min_vel_reg;

    // gesture state
    logic          armed_reg;
    logic [CB-1:0] start_x_reg;
    logic [CB-1:0] start_y_reg;
    logic [TB-1:0] start_t_reg;

    // per-event flags
    logic                           early_none_reg;
    logic                           t_big_reg;
    logic [swdc_pkg::DIR_W-1:0]     dir_pass_reg;
    logic [swdc_pkg::DIR_W-1:0]     dir_res_reg;
    logic [swdc_pkg::DIST_W-1:0]    dist2_reg;

    // output register
    logic                       m_valid_reg;
    logic [swdc_pkg::DIR_W-1:0] m_dir_reg;

    // input field unpack
    logic [swdc_pkg::MODE_W-1:0] in_mode;
    logic [CB-1:0]               in_x;
    logic [CB-1:0]               in_y;
    logic [TB-1:0]               in_t;

    assign in_mode = s_tdata[swdc_pkg::MODE_W-1:0];
    assign in_x    = s_tdata[swdc_pkg::MODE_W +: CB];
    assign in_y    = s_tdata[swdc_pkg::MODE_W + CB +: CB];
    assign in_t    = s_tdata[swdc_pkg::MODE_W + 2 * CB +: TB];

    logic s_fire;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // travel, elapsed time and direction from the incoming sample
    logic [CB-1:0]              ax_c, ay_c;
    logic                       dx_pos_c, dy_pos_c;
    logic [TB-1:0]              dt_c;
    logic                       early_none_c;
    logic                       t_big_c;
    logic                       classify_c;
    logic [swdc_pkg::DIR_W-1:0] dir_pass_c;

    always_comb begin
        dx_pos_c     = in_x > start_x_reg;
        dy_pos_c     = in_y > start_y_reg;
        ax_c         = dx_pos_c ? (in_x - start_x_reg) : (start_x_reg - in_x);
        ay_c         = dy_pos_c ? (in_y - start_y_reg) : (start_y_reg - in_y);
        dt_c         = in_t - start_t_reg;
        early_none_c = !(in_t > start_t_reg)
                       || ((in_mode == swdc_pkg::MODE_UP) && (dt_c > TB'(max_dur_reg)));
        t_big_c      = (dt_c >> swdc_pkg::VEL_BITS) != '0;
        classify_c   = armed_reg
                       && ((in_mode == swdc_pkg::MODE_MOVE) || (in_mode == swdc_pkg::MODE_UP));
        if (ax_c > ay_c) begin
            dir_pass_c = dx_pos_c ? swdc_pkg::DIR_RIGHT : swdc_pkg::DIR_LEFT;
        end else begin
            dir_pass_c = dy_pos_c ? swdc_pkg::DIR_DOWN : swdc_pkg::DIR_UP;
        end
    end

    // serial multipliers: ax^2, ay^2, min_distance^2, v*T then p^2
    logic                        mul1_start, mul2_start;
    logic [swdc_pkg::PROD_W-1:0] pax, pay, pmd, pvt;
    logic                        ax_done, ay_done, md_done, vt_done;
    logic [MW-1:0]               vt_a, vt_b;

    assign mul1_start = s_fire && classify_c;

    swdc_mul u_mul_ax (
        .aclk(aclk), .aresetn(aresetn), .start(mul1_start),
        .mcand(MW'(ax_c)), .mplier(MW'(ax_c)), .prod(pax), .done(ax_done)
    );

    swdc_mul u_mul_ay (
        .aclk(aclk), .aresetn(aresetn), .start(mul1_start),
        .mcand(MW'(ay_c)), .mplier(MW'(ay_c)), .prod(pay), .done(ay_done)
    );

    swdc_mul u_mul_md (
        .aclk(aclk), .aresetn(aresetn), .start(mul1_start),
        .mcand(MW'(min_dist_reg)), .mplier(MW'(min_dist_reg)), .prod(pmd), .done(md_done)
    );

    // shared unit: v*T first, then squares its own product
    assign vt_a = mul2_start ? pvt[MW-1:0] : MW'(dt_c);
    assign vt_b = mul2_start ? pvt[MW-1:0] : MW'(min_vel_reg);

    swdc_mul u_mul_vt (
        .aclk(aclk), .aresetn(aresetn), .start(mul1_start || mul2_start),
        .mcand(vt_a), .mplier(vt_b), .prod(pvt), .done(vt_done)
    );

    // distance and velocity decisions
    logic [swdc_pkg::DIST_W-1:0] dist2_c;
    logic                        too_short_c, vel_zero_c, p_big_c, mul1_done;
    logic                        stall_out;
    logic [swdc_pkg::LHS_W-1:0]  lhs_c;
    logic                        too_slow_c;

    always_comb begin
        mul1_done   = ax_done && ay_done && md_done && vt_done && (state_reg == ST_MUL1);
        dist2_c     = {1'b0, pax} + {1'b0, pay};
        too_short_c = dist2_c < {1'b0, pmd};
        vel_zero_c  = (min_vel_reg == '0);
        p_big_c     = pvt[swdc_pkg::PROD_W-1:swdc_pkg::VEL_BITS] != '0;
        mul2_start  = mul1_done && !early_none_reg && !too_short_c && !vel_zero_c
                      && !t_big_reg && !p_big_c;
        lhs_c       = swdc_pkg::LHS_W'(dist2_reg) << swdc_pkg::DIST_SHIFT;
        too_slow_c  = lhs_c < swdc_pkg::LHS_W'(pvt);
        stall_out   = m_valid_reg && !m_tready;
    end

    // sequencer and gesture state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            armed_reg   <= 1'b0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_t_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        early_none_reg <= early_none_c;
                        t_big_reg      <= t_big_c;
                        dir_pass_reg   <= dir_pass_c;
                        dir_res_reg    <= swdc_pkg::DIR_NONE;
                        state_reg      <= classify_c ? ST_MUL1 : ST_DONE;
                        unique case (in_mode)
                            swdc_pkg::MODE_DOWN: begin
                                armed_reg   <= 1'b1;
                                start_x_reg <= in_x;
                                start_y_reg <= in_y;
                                start_t_reg <= in_t;
                            end
                            swdc_pkg::MODE_UP: begin
                                armed_reg <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_MUL1: begin
                    if (mul1_done) begin
                        dist2_reg <= dist2_c;
                        if (mul2_start) begin
                            state_reg <= ST_MUL2;
                        end else begin
                            state_reg <= ST_DONE;
                            if (early_none_reg || too_short_c || t_big_reg || p_big_c) begin
                                dir_res_reg <= vel_zero_c && !early_none_reg && !too_short_c
                                               ? dir_pass_reg : swdc_pkg::DIR_NONE;
                            end else begin
                                dir_res_reg <= dir_pass_reg;
                            end
                        end
                    end
                end
                ST_MUL2: begin
                    if (vt_done) begin
                        dir_res_reg <= too_slow_c ? swdc_pkg::DIR_NONE : dir_pass_reg;
                        state_reg   <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!stall_out) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            m_dir_reg   <= swdc_pkg::DIR_NONE;
        end else if ((state_reg == ST_DONE) && !stall_out) begin
            m_valid_reg <= 1'b1;
            m_dir_reg   <= dir_res_reg;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(swdc_pkg::M_TDATA_W - swdc_pkg::DIR_W){1'b0}}, m_dir_reg};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dur_reg  <= swdc_pkg::MAXD_RESET;
            min_dist_reg <= swdc_pkg::MIND_RESET;
            min_vel_reg  <= swdc_pkg::MINV_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                swdc_pkg::REG_MAX_DURATION: max_dur_reg  <= cfg_wdata[swdc_pkg::MAXD_W-1:0];
                swdc_pkg::REG_MIN_DISTANCE: min_dist_reg <= cfg_wdata[swdc_pkg::MIND_W-1:0];
                swdc_pkg::REG_MIN_VELOCITY: min_vel_reg  <= cfg_wdata[swdc_pkg::MINV_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

/* design/swdc_mul.sv */
// Bit-serial shift-add multiplier: one multiplier bit per cycle
module swdc_mul (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [swdc_pkg::MUL_W-1:0]  mcand,
    input  logic [swdc_pkg::MUL_W-1:0]  mplier,
    output logic [swdc_pkg::PROD_W-1:0] prod,
    output logic                        done
);

    logic [swdc_pkg::PROD_W-1:0]    mcand_reg;
    logic [swdc_pkg::MUL_W-1:0]     mplier_reg;
    logic [swdc_pkg::PROD_W-1:0]    acc_reg;
    logic [swdc_pkg::PROD_W-1:0]    acc_next;
    logic [swdc_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    // conditional add of the shifted multiplicand
    always_comb begin
        acc_next = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= swdc_pkg::MUL_CNT_W'(swdc_pkg::MUL_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == swdc_pkg::MUL_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath shift registers
    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg  <= swdc_pkg::PROD_W'(mcand);
            mplier_reg <= mplier;
            acc_reg    <= '0;
        end else if (busy_reg) begin
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
            acc_reg    <= acc_next;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

/* design/swdc_checker.sv */
module swdc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [swdc_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one word in flight: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous word in flight");

    // direction code in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[swdc_pkg::DIR_W-1:0] <= swdc_pkg::DIR_DOWN)
        else $error("direction code out of range");

    // reset clears the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind swipe_direction_classifier swdc_checker u_swdc_checker (.*);

/* sim/testbench.sv */
module testbench;
    import swdc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_WORDS  = 240;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 500;

    // One touch event, mode in the lowest bits
    typedef struct packed {
        logic [TIME_BITS-1:0]  time_ms;
        logic [COORD_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0] pos_x;
        logic [MODE_W-1:0]     mode;
    } touch_t;

    typedef struct {
        touch_t           ev;
        bit               typed;
        logic [DIR_W-1:0] dir;
    } script_row_t;

    typedef struct {
        logic [MAXD_W-1:0] max_dur;
        logic [MIND_W-1:0] min_dist;
        logic [MINV_W-1:0] min_vel;
    } thresholds_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Predictor copy of the thresholds and gesture state
    logic [MAXD_W-1:0]     pr_max_dur;
    logic [MIND_W-1:0]     pr_min_dist;
    logic [MINV_W-1:0]     pr_min_vel;
    bit                    pr_armed;
    logic [COORD_BITS-1:0] pr_start_x;
    logic [COORD_BITS-1:0] pr_start_y;
    logic [TIME_BITS-1:0]  pr_start_ms;

    logic [DIR_W-1:0] dir_expected[$];
    int               fail_count;
    int               words_taken;
    int               cycles;
    int               burst_left;
    logic [TIME_BITS-1:0] clock_ms;
    script_row_t      script [25];
    thresholds_t      phases [8];

    swipe_direction_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Classify travel from the latched start point; squared compares only
    function automatic logic [DIR_W-1:0] swipe_dir(touch_t ev, bit on_up);
        longint unsigned ax, ay, dist2, dt, p, lhs, dmin;
        if (ev.time_ms <= pr_start_ms) return DIR_NONE;
        dt = ev.time_ms - pr_start_ms;
        if (on_up && dt > pr_max_dur) return DIR_NONE;
        ax = (ev.pos_x >= pr_start_x) ? ev.pos_x - pr_start_x : pr_start_x - ev.pos_x;
        ay = (ev.pos_y >= pr_start_y) ? ev.pos_y - pr_start_y : pr_start_y - ev.pos_y;
        dist2 = ax * ax + ay * ay;
        dmin = pr_min_dist;
        if (dist2 < dmin * dmin) return DIR_NONE;
        if (pr_min_vel != 0) begin
            if (dt >= (64'd1 << VEL_BITS)) return DIR_NONE;
            p = pr_min_vel * dt;
            if (p >= (64'd1 << VEL_BITS)) return DIR_NONE;
            lhs = dist2 << DIST_SHIFT;
            if (lhs < p * p) return DIR_NONE;
        end
        if (ax > ay) return (ev.pos_x > pr_start_x) ? DIR_RIGHT : DIR_LEFT;
        return (ev.pos_y > pr_start_y) ? DIR_DOWN : DIR_UP;
    endfunction

    // Advance the gesture state by one event and return its direction
    function automatic logic [DIR_W-1:0] classify_touch(touch_t ev);
        logic [DIR_W-1:0] dir;
        dir = DIR_NONE;
        case (ev.mode)
            MODE_DOWN: begin
                pr_armed    = 1'b1;
                pr_start_x  = ev.pos_x;
                pr_start_y  = ev.pos_y;
                pr_start_ms = ev.time_ms;
            end
            MODE_MOVE: begin
                if (pr_armed) dir = swipe_dir(ev, 1'b0);
            end
            MODE_UP: begin
                if (pr_armed) begin
                    pr_armed = 1'b0;
                    dir = swipe_dir(ev, 1'b1);
                end
            end
            default: ;
        endcase
        return dir;
    endfunction

    function automatic script_row_t step_row(logic [MODE_W-1:0] mode,
            logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
            logic [TIME_BITS-1:0] t, bit typed, logic [DIR_W-1:0] dir);
        script_row_t r;
        r.ev.mode    = mode;
        r.ev.pos_x   = x;
        r.ev.pos_y   = y;
        r.ev.time_ms = t;
        r.typed      = typed;
        r.dir        = dir;
        return r;
    endfunction

    function automatic logic [COORD_BITS-1:0] nudge(logic [COORD_BITS-1:0] p, int step);
        int v;
        v = int'(p) + step;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[COORD_BITS-1:0];
    endfunction

    // Offer one word in bursts with random gaps; record its direction on accept
    task automatic send_touch(touch_t ev, bit typed, logic [DIR_W-1:0] typed_dir);
        int gap;
        logic [DIR_W-1:0] dir;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(ev);
        do @(posedge aclk); while (!s_tready);
        dir = classify_touch(ev);
        dir_expected.push_back(typed ? typed_dir : dir);
        @(negedge aclk);
    endtask

    task automatic send_event(logic [MODE_W-1:0] mode, logic [COORD_BITS-1:0] x,
                              logic [COORD_BITS-1:0] y);
        touch_t ev;
        ev.mode = mode;
        ev.pos_x = x;
        ev.pos_y = y;
        ev.time_ms = clock_ms;
        send_touch(ev, 1'b0, DIR_NONE);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (dir_expected.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Write all three thresholds on consecutive cycles
    task automatic load_thresholds(thresholds_t th);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MAX_DURATION;
        cfg_wdata <= CFG_DATA_W'(th.max_dur);
        @(negedge aclk);
        cfg_index <= REG_MIN_DISTANCE;
        cfg_wdata <= CFG_DATA_W'(th.min_dist);
        @(negedge aclk);
        cfg_index <= REG_MIN_VELOCITY;
        cfg_wdata <= CFG_DATA_W'(th.min_vel);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        pr_max_dur  = th.max_dur;
        pr_min_dist = th.min_dist;
        pr_min_vel  = th.min_vel;
        @(negedge aclk);
    endtask

    // Mostly whole gestures (down, moves, up) with random travel; some noise
    task automatic run_gestures(int count);
        int sent, moves, main_step, cross_step, k, gap;
        bit horiz;
        logic [COORD_BITS-1:0] x, y;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 8) begin
                if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
                else clock_ms += $urandom_range(1, 200);
                x = COORD_BITS'($urandom_range(0, 65535));
                y = COORD_BITS'($urandom_range(0, 65535));
                horiz = 1'($urandom_range(0, 1));
                main_step = $urandom_range(0, 4000);
                cross_step = $urandom_range(0, 1500);
                if ($urandom_range(0, 1)) main_step = -main_step;
                if ($urandom_range(0, 1)) cross_step = -cross_step;
                send_event(MODE_DOWN, x, y);
                sent++;
                moves = $urandom_range(0, 6);
                for (k = 0; k <= moves; k++) begin
                    gap = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
                    if ($urandom_range(0, 14) == 0) clock_ms -= $urandom_range(1, 5);
                    else clock_ms += gap;
                    if (k == moves && $urandom_range(0, 7) == 0)
                        clock_ms += $urandom_range(400, 2000);
                    x = nudge(x, (horiz ? main_step : cross_step)
                                 + $urandom_range(0, 400) - 200);
                    y = nudge(y, (horiz ? cross_step : main_step)
                                 + $urandom_range(0, 400) - 200);
                    if (k < moves) begin
                        send_event(MODE_MOVE, x, y);
                        sent++;
                    end else if ($urandom_range(0, 9) != 0) begin
                        send_event(MODE_UP, x, y);
                        sent++;
                    end
                end
            end else begin
                for (k = $urandom_range(1, 4); k > 0; k--) begin
                    clock_ms = $urandom;
                    send_event(MODE_W'($urandom_range(0, 3)), COORD_BITS'($urandom),
                               COORD_BITS'($urandom));
                    sent++;
                end
            end
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        logic [DIR_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            words_taken++;
            if (dir_expected.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result word, direction %0d", m_tdata[DIR_W-1:0]);
            end else begin
                want = dir_expected.pop_front();
                if (m_tdata[DIR_W-1:0] !== want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("direction mismatch at result %0d: expected %0d, got %0d",
                                 words_taken, want, m_tdata[DIR_W-1:0]);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: changing stall styles, plus one long hold to back up the input
    initial begin
        int style, left, hold_left, tick;
        bit held;
        style = 0;
        left = 0;
        hold_left = 0;
        tick = 0;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (!held && words_taken >= HOLD_AFTER) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (left == 0) begin
                    style = $urandom_range(0, 3);
                    left = $urandom_range(16, 96);
                end
                left--;
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // Main sequence
    initial begin
        int i;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_MAX_DURATION;
        cfg_wdata = '0;
        fail_count = 0;
        words_taken = 0;
        cycles = 0;
        burst_left = 0;
        clock_ms = 0;
        pr_max_dur  = MAXD_RESET;
        pr_min_dist = MIND_RESET;
        pr_min_vel  = MINV_RESET;
        pr_armed    = 1'b0;
        pr_start_x  = '0;
        pr_start_y  = '0;
        pr_start_ms = '0;

        // Directed events at reset thresholds
        script = '{
            step_row(MODE_MOVE,  16'h1234, 16'h4321, 32'd10,         1, DIR_NONE),
            step_row(MODE_UP,    16'hFFFF, 16'hFFFF, 32'd20,         1, DIR_NONE),
            step_row(MODE_SPARE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,  1, DIR_NONE),
            step_row(MODE_DOWN,  16'h8000, 16'h8000, 32'd1000,       1, DIR_NONE),
            step_row(MODE_MOVE,  16'h8000, 16'h8000, 32'd1000,       1, DIR_NONE),
            step_row(MODE_MOVE,  16'hFFFF, 16'h8000, 32'd999,        1, DIR_NONE),
            step_row(MODE_MOVE,  16'hFFFF, 16'h8000, 32'd1010,       0, DIR_NONE),
            step_row(MODE_MOVE,  16'h0000, 16'h8000, 32'd1010,       0, DIR_NONE),
            step_row(MODE_MOVE,  16'h8000, 16'h0000, 32'd1010,       0, DIR_NONE),
            step_row(MODE_MOVE,  16'h8000, 16'hFFFF, 32'd1010,       0, DIR_NONE),
            step_row(MODE_MOVE,  16'hA000, 16'hA000, 32'd1010,       0, DIR_NONE),
            step_row(MODE_MOVE,  16'h8001, 16'h8000, 32'd1010,       0, DIR_NONE),
            step_row(MODE_MOVE,  16'hFFFF, 16'h8000, 32'd101000,     0, DIR_NONE),
            step_row(MODE_MOVE,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,  0, DIR_NONE),
            step_row(MODE_UP,    16'h0000, 16'h8000, 32'd1501,       0, DIR_NONE),
            step_row(MODE_MOVE,  16'h0000, 16'h8000, 32'd1510,       1, DIR_NONE),
            step_row(MODE_DOWN,  16'h0000, 16'h0000, 32'd0,         1, DIR_NONE),
            step_row(MODE_UP,    16'hFFFF, 16'hFFFF, 32'd500,        0, DIR_NONE),
            step_row(MODE_DOWN,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFE,  1, DIR_NONE),
            step_row(MODE_MOVE,  16'h0000, 16'h0000, 32'hFFFF_FFFF,  0, DIR_NONE),
            step_row(MODE_DOWN,  16'd100,  16'd100,  32'd50,         1, DIR_NONE),
            step_row(MODE_DOWN,  16'h4000, 16'h4000, 32'd60,         1, DIR_NONE),
            step_row(MODE_SPARE, 16'h0000, 16'h0000, 32'd0,         1, DIR_NONE),
            step_row(MODE_UP,    16'h4000, 16'h4000, 32'd61,         0, DIR_NONE),
            step_row(MODE_UP,    16'h0000, 16'h0000, 32'd0,         1, DIR_NONE)
        };

        // Threshold settings, extremes first
        phases = '{
            '{16'd65535, 16'd0,     24'd0},
            '{16'd0,     16'd65535, 24'd16777215},
            '{16'd500,   16'd6554,  24'd8389},
            '{16'd1000,  16'd2000,  24'd100000},
            '{MAXD_W'($urandom_range(0, 2000)), MIND_W'($urandom_range(0, 20000)),
              MINV_W'($urandom_range(0, 50000))},
            '{16'd200,   16'd0,     24'd16777215},
            '{16'd0,     16'd0,     24'd0},
            '{MAXD_W'($urandom), MIND_W'($urandom_range(0, 12000)),
              MINV_W'($urandom_range(0, 30000))}
        };

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < 25; i++)
            send_touch(script[i].ev, script[i].typed, script[i].dir);

        for (i = 0; i < 8; i++) begin
            wait_idle();
            load_thresholds(phases[i]);
            run_gestures(PHASE_WORDS);
        end

        // Drain
        s_tvalid <= 1'b0;
        while (dir_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (dir_expected.size() != 0) begin
            $display("%0d results never arrived", dir_expected.size());
            fail_count += dir_expected.size();
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
